// ===== rtl/hdf_pkg.sv =====
`timescale 1ns / 1ps

package hdf_pkg;

    // one input request: a raw byte and the end-of-dump mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } hdf_in_t;

    // one output request: a pair of characters
    typedef struct packed {
        logic [6:0] first_char;
        logic [6:0] second_char;
        logic       second_valid;
        logic       run_last;
        logic       dump_end;
    } hdf_out_t;

    // one character from the sequencer to the pair packer
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       fin;
    } hdf_char_t;

    localparam logic [6:0] CH_TAB   = 7'h09;
    localparam logic [6:0] CH_NL    = 7'h0A;
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_DOT   = 7'h2E;
    localparam logic [6:0] CH_COLON = 7'h3A;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_UPPER_A = 7'h41;
    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;
    localparam logic [3:0] LAST_POS = 4'hF;

    function automatic logic [6:0] hex_digit(input logic [3:0] v);
        logic [6:0] r;
        if (v < 4'd10)
        begin
            r = CH_ZERO + {3'b000, v};
        end
        else
        begin
            r = CH_UPPER_A + {3'b000, v - 4'd10};
        end
        return r;
    endfunction

    function automatic logic [6:0] show_char(input logic [7:0] b);
        logic [6:0] r;
        if (b < PRINT_LO || b > PRINT_HI)
        begin
            r = CH_DOT;
        end
        else
        begin
            r = b[6:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/hdf_seq.sv =====
`timescale 1ns / 1ps

module hdf_seq import hdf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_stall,
    input  hdf_in_t   byte_item,
    output logic      char_valid,
    output hdf_char_t char_item,
    input  logic      char_take
);

    localparam logic [3:0] PH_TAB   = 4'd0;
    localparam logic [3:0] PH_OFF   = 4'd1;
    localparam logic [3:0] PH_COLON = 4'd2;
    localparam logic [3:0] PH_SP1   = 4'd3;
    localparam logic [3:0] PH_HEXH  = 4'd4;
    localparam logic [3:0] PH_HEXL  = 4'd5;
    localparam logic [3:0] PH_HEXSP = 4'd6;
    localparam logic [3:0] PH_PAD   = 4'd7;
    localparam logic [3:0] PH_SEP   = 4'd8;
    localparam logic [3:0] PH_ASC   = 4'd9;
    localparam logic [3:0] PH_NL    = 4'd10;

    logic        busy_reg, busy_next;
    logic [3:0]  phase_reg, phase_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [1:0]  sub_reg, sub_next;
    logic [7:0]  byte_reg;
    logic        fin_reg;
    logic [3:0]  pos_reg;
    logic [15:0] line_off_reg;
    logic [15:0] offset_reg;
    logic [6:0]  col_reg [16];

    logic        accept;
    logic        close_line;
    logic [3:0]  nib;
    logic        use_hex;
    logic [6:0]  plain_ch;
    logic        last_ch;

    assign accept     = byte_valid && !busy_reg;
    assign byte_stall = busy_reg;
    assign char_valid = busy_reg;
    assign close_line = (pos_reg == LAST_POS) || fin_reg;

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        sub_next   = sub_reg;
        busy_next  = busy_reg;
        nib        = byte_reg[3:0];
        use_hex    = 1'b0;
        plain_ch   = CH_SPACE;
        last_ch    = 1'b0;
        case (phase_reg)
            PH_TAB:
            begin
                plain_ch   = CH_TAB;
                phase_next = PH_OFF;
                cnt_next   = '0;
            end
            PH_OFF:
            begin
                use_hex = 1'b1;
                case (cnt_reg[1:0])
                    2'd0:    nib = line_off_reg[15:12];
                    2'd1:    nib = line_off_reg[11:8];
                    2'd2:    nib = line_off_reg[7:4];
                    default: nib = line_off_reg[3:0];
                endcase
                if (cnt_reg[1:0] == 2'd3)
                begin
                    phase_next = PH_COLON;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            PH_COLON:
            begin
                plain_ch   = CH_COLON;
                phase_next = PH_SP1;
            end
            PH_SP1:
            begin
                phase_next = PH_HEXH;
            end
            PH_HEXH:
            begin
                use_hex    = 1'b1;
                nib        = byte_reg[7:4];
                phase_next = PH_HEXL;
            end
            PH_HEXL, PH_HEXSP:
            begin
                use_hex = (phase_reg == PH_HEXL);
                if (phase_reg == PH_HEXL && pos_reg[0])
                begin
                    phase_next = PH_HEXSP;
                end
                else if (!close_line)
                begin
                    last_ch   = 1'b1;
                    busy_next = 1'b0;
                end
                else if (pos_reg == LAST_POS)
                begin
                    phase_next = PH_SEP;
                end
                else
                begin
                    phase_next = PH_PAD;
                    cnt_next   = pos_reg + 4'd1;
                    sub_next   = 2'd0;
                end
            end
            PH_PAD:
            begin
                // two spaces per empty position, a third after odd ones
                if (sub_reg == 2'd0)
                begin
                    sub_next = 2'd1;
                end
                else if (sub_reg == 2'd1 && cnt_reg[0])
                begin
                    sub_next = 2'd2;
                end
                else
                begin
                    sub_next = 2'd0;
                    if (cnt_reg == LAST_POS)
                    begin
                        phase_next = PH_SEP;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 4'd1;
                    end
                end
            end
            PH_SEP:
            begin
                phase_next = PH_ASC;
                cnt_next   = '0;
            end
            PH_ASC:
            begin
                plain_ch = (cnt_reg <= pos_reg) ? col_reg[cnt_reg] : CH_SPACE;
                if (cnt_reg == LAST_POS)
                begin
                    phase_next = PH_NL;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            PH_NL:
            begin
                plain_ch  = CH_NL;
                last_ch   = 1'b1;
                busy_next = 1'b0;
            end
            default:
            begin
                last_ch   = 1'b1;
                busy_next = 1'b0;
            end
        endcase
    end

    // single shared nibble-to-hex converter
    assign char_item.ch   = use_hex ? hex_digit(nib) : plain_ch;
    assign char_item.last = last_ch;
    assign char_item.fin  = fin_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            phase_reg  <= PH_TAB;
            cnt_reg    <= '0;
            sub_reg    <= '0;
            offset_reg <= '0;
        end
        else if (accept)
        begin
            busy_reg   <= 1'b1;
            phase_reg  <= (offset_reg[3:0] == 4'd0) ? PH_TAB : PH_HEXH;
            cnt_reg    <= '0;
            sub_reg    <= '0;
            offset_reg <= byte_item.final_byte ? 16'd0 : offset_reg + 16'd1;
        end
        else if (busy_reg && char_take)
        begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg     <= byte_item.data_byte;
            fin_reg      <= byte_item.final_byte;
            pos_reg      <= offset_reg[3:0];
            line_off_reg <= offset_reg;
            col_reg[offset_reg[3:0]] <= show_char(byte_item.data_byte);
        end
    end

endmodule

// ===== rtl/hex_dump_formatter_unit.sv =====
`timescale 1ns / 1ps

// hex dump formatter, 16 bytes per 65-character line
// input channel byte_*: one raw byte per request, final_byte closes the dump
// output channel text_*: two ascii characters per request, the second one
//   flagged by second_valid; run_last marks the last pair of a byte and
//   dump_end the last pair of the whole dump
// a sequencer walks the text of one byte one character per cycle, held while a
//   stalled pair waits, through a single shared hex digit converter; the
//   characters are packed into pairs; a byte gives 2 or 3 characters mid-line,
//   7 more at a line start, and up to 65 on a byte that opens and closes a line
//   (padding, ascii column and newline); byte_stall stays high for the whole
//   character run
// the first pair of a byte reaches the output register once its second
//   character is taken
// a new byte is taken while the last pair still waits in the output register
// when text_stall is high and a pair waits, the output register holds and the
//   sequencer pauses on the next pair; nothing is lost or repeated
// reset clears the line offset to zero and empties the output register; the
//   ascii column holds no state that needs clearing
module hex_dump_formatter_unit import hdf_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_stall,
    input  hdf_in_t  byte_item,
    output logic     text_valid,
    input  logic     text_stall,
    output hdf_out_t text_item
);

    logic      char_valid;
    hdf_char_t char_item;
    logic      char_take;

    logic      half_reg;
    logic [6:0] first_reg;
    logic      out_valid_reg;
    hdf_out_t  out_reg;
    hdf_out_t  out_next;

    logic      need_push;
    logic      out_free;
    logic      push;

    hdf_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_item  (char_item),
        .char_take  (char_take)
    );

    // a pair is complete on the second character or on the last one
    assign need_push = half_reg || char_item.last;
    assign out_free  = !out_valid_reg || !text_stall;
    assign char_take = char_valid && (!need_push || out_free);
    assign push      = char_take && need_push;

    always_comb
    begin
        if (half_reg)
        begin
            out_next.first_char   = first_reg;
            out_next.second_char  = char_item.ch;
            out_next.second_valid = 1'b1;
        end
        else
        begin
            out_next.first_char   = char_item.ch;
            out_next.second_char  = 7'd0;
            out_next.second_valid = 1'b0;
        end
        out_next.run_last = char_item.last;
        out_next.dump_end = char_item.last && char_item.fin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (char_take)
            begin
                half_reg <= !half_reg && !char_item.last;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!text_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (char_take && !need_push)
        begin
            first_reg <= char_item.ch;
        end
        if (push)
        begin
            out_reg <= out_next;
        end
    end

    assign text_valid = out_valid_reg;
    assign text_item  = out_reg;

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_item.dump_end |-> text_item.run_last)
        else $error("dump_end without run_last");

    a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && !text_item.second_valid |-> text_item.second_char == 7'd0
            && text_item.run_last)
        else $error("single character pair not closing a byte");

    a_idle_packer_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !byte_stall |-> !half_reg)
        else $error("half pair left over when idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && !byte_stall |=> byte_stall)
        else $error("sequencer not busy after a byte");

endmodule

// ===== verif/hex_dump_formatter_unit_tb.sv =====
`timescale 1ns / 1ps

module hex_dump_formatter_unit_tb;
    import hdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_TAIL     = 100;
    localparam int RANDOM_BYTES   = 250;

    localparam logic [6:0] TAB_CHAR   = 7'h09;
    localparam logic [6:0] NL_CHAR    = 7'h0A;
    localparam logic [6:0] SPACE_CHAR = 7'h20;
    localparam logic [6:0] DOT_CHAR   = 7'h2E;
    localparam logic [6:0] COLON_CHAR = 7'h3A;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY} stall_mode_e;

    class dump_text_board;
        logic [15:0] line_offset;
        logic [6:0]  ascii_line [16];
        hdf_out_t    pairs_due [$];
        int          errors;
        int          bytes_seen;
        int          dumps_seen;
        int          pairs_checked;

        function new();
            line_offset   = '0;
            errors        = 0;
            bytes_seen    = 0;
            dumps_seen    = 0;
            pairs_checked = 0;
        endfunction

        function logic [6:0] nibble_char(input logic [3:0] v);
            logic [6:0] c;
            if (v < 4'd10)
            begin
                c = 7'h30 + {3'b000, v};
            end
            else
            begin
                c = 7'h41 + {3'b000, v} - 7'd10;
            end
            return c;
        endfunction

        // works out every character pair that one byte request gives
        function void note_byte(input hdf_in_t req);
            logic [6:0] chars [$];
            hdf_out_t   pair;
            int         pos;
            int         j;
            int         k;
            pos = int'(line_offset[3:0]);
            if (pos == 0)
            begin
                chars.push_back(TAB_CHAR);
                chars.push_back(nibble_char(line_offset[15:12]));
                chars.push_back(nibble_char(line_offset[11:8]));
                chars.push_back(nibble_char(line_offset[7:4]));
                chars.push_back(nibble_char(line_offset[3:0]));
                chars.push_back(COLON_CHAR);
                chars.push_back(SPACE_CHAR);
            end
            chars.push_back(nibble_char(req.data_byte[7:4]));
            chars.push_back(nibble_char(req.data_byte[3:0]));
            if (pos % 2 == 1)
            begin
                chars.push_back(SPACE_CHAR);
            end
            if (req.data_byte < 8'h20 || req.data_byte > 8'h7E)
            begin
                ascii_line[pos] = DOT_CHAR;
            end
            else
            begin
                ascii_line[pos] = req.data_byte[6:0];
            end
            // line closes: pad the hex area, then the ascii column
            if (pos == 15 || req.final_byte)
            begin
                for (j = pos + 1; j < 16; j++)
                begin
                    chars.push_back(SPACE_CHAR);
                    chars.push_back(SPACE_CHAR);
                    if (j % 2 == 1)
                    begin
                        chars.push_back(SPACE_CHAR);
                    end
                end
                chars.push_back(SPACE_CHAR);
                for (j = 0; j < 16; j++)
                begin
                    chars.push_back((j <= pos) ? ascii_line[j] : SPACE_CHAR);
                end
                chars.push_back(NL_CHAR);
            end
            if (req.final_byte)
            begin
                line_offset = '0;
                dumps_seen++;
            end
            else
            begin
                line_offset = line_offset + 16'd1;
            end
            bytes_seen++;
            for (k = 0; k < chars.size(); k += 2)
            begin
                pair.first_char = chars[k];
                if (k + 1 < chars.size())
                begin
                    pair.second_char  = chars[k + 1];
                    pair.second_valid = 1'b1;
                end
                else
                begin
                    pair.second_char  = '0;
                    pair.second_valid = 1'b0;
                end
                pair.run_last = (k + 2 >= chars.size());
                pair.dump_end = pair.run_last && req.final_byte;
                pairs_due.push_back(pair);
            end
        endfunction

        function void check_pair(input hdf_out_t got);
            hdf_out_t want;
            if (pairs_due.size() == 0)
            begin
                $error("text request with nothing expected: %p", got);
                errors++;
                return;
            end
            want = pairs_due.pop_front();
            pairs_checked++;
            if (got.first_char !== want.first_char)
            begin
                $error("first_char: expected %0h actual %0h", want.first_char, got.first_char);
                errors++;
            end
            if (got.second_char !== want.second_char)
            begin
                $error("second_char: expected %0h actual %0h",
                       want.second_char, got.second_char);
                errors++;
            end
            if (got.second_valid !== want.second_valid)
            begin
                $error("second_valid: expected %0h actual %0h",
                       want.second_valid, got.second_valid);
                errors++;
            end
            if (got.run_last !== want.run_last)
            begin
                $error("run_last: expected %0h actual %0h", want.run_last, got.run_last);
                errors++;
            end
            if (got.dump_end !== want.dump_end)
            begin
                $error("dump_end: expected %0h actual %0h", want.dump_end, got.dump_end);
                errors++;
            end
        endfunction

        function int pending();
            return pairs_due.size();
        endfunction

        function void close_out();
            if (pairs_due.size() != 0)
            begin
                $error("%0d text requests never arrived", pairs_due.size());
                errors += pairs_due.size();
            end
        endfunction
    endclass

    logic     clk        = 1'b0;
    logic     rst_n      = 1'b0;
    logic     byte_valid = 1'b0;
    logic     byte_stall;
    hdf_in_t  byte_item  = '0;
    logic     text_valid;
    logic     text_stall = 1'b0;
    hdf_out_t text_item;

    dump_text_board board = new();
    stall_mode_e    stall_mode  = STALL_NONE;
    int             stall_count = 0;
    int             quiet_cycles = 0;
    bit             gaps_on = 1'b0;
    int             burst_left = 0;
    logic [7:0]     line_pattern [16] = '{8'h00, 8'hFF, 8'h1F, 8'h20, 8'h7E, 8'h7F,
                                          8'h80, 8'h30, 8'h39, 8'h3A, 8'h40, 8'h5A,
                                          8'h61, 8'h7A, 8'hA5, 8'h5A};
    logic [7:0]     edge_bytes [6] = '{8'h00, 8'h1F, 8'h20, 8'h7E, 8'h7F, 8'hFF};

    hex_dump_formatter_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_item  (byte_item),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .text_item  (text_item)
    );

    always #5 clk = ~clk;

    // receiver back-pressure
    always @(negedge clk)
    begin
        case (stall_mode)
            STALL_NONE:
            begin
                text_stall <= 1'b0;
            end
            STALL_RANDOM:
            begin
                text_stall <= ($urandom_range(0, 2) == 0);
            end
            default:
            begin
                if (stall_count == 0)
                begin
                    if (text_stall)
                    begin
                        text_stall <= 1'b0;
                        stall_count = $urandom_range(0, 15);
                    end
                    else
                    begin
                        text_stall <= 1'b1;
                        stall_count = $urandom_range(1, 12);
                    end
                end
                else
                begin
                    stall_count = stall_count - 1;
                end
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                board.note_byte(byte_item);
            end
            if (text_valid && !text_stall)
            begin
                board.check_pair(text_item);
            end
            if ((byte_valid && !byte_stall) || (text_valid && !text_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("timeout: no request moved for %0d cycles", quiet_cycles);
                    $display("hex_dump_formatter_unit verification failed");
                    $finish;
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_byte(input logic [7:0] data, input logic last);
        hdf_in_t req;
        req.data_byte  = data;
        req.final_byte = last;
        byte_item  <= req;
        byte_valid <= 1'b1;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic idle_sender(input int cycles);
        byte_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic pace_sender();
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                idle_sender($urandom_range(1, 8));
                burst_left = $urandom_range(0, 12);
            end
            else
            begin
                burst_left = burst_left - 1;
            end
        end
    endtask

    task automatic drain_text();
        idle_sender(1);
        while (board.pending() != 0)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [7:0] pick_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0: b = 8'($urandom_range(8'h20, 8'h7E));
            1: b = edge_bytes[$urandom_range(0, 5)];
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    initial
    begin
        int i;
        int dump_len;
        int sent;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // one-byte dump: line opens and closes on the same byte
        stall_mode = STALL_RANDOM;
        send_byte(8'h41, 1'b1);
        // a full line of boundary bytes, then a final byte opening line two
        for (i = 0; i < 16; i++)
        begin
            send_byte(line_pattern[i], 1'b0);
        end
        send_byte(8'hC3, 1'b1);
        // final on an odd position
        send_byte(8'h7E, 1'b0);
        send_byte(8'h0F, 1'b1);
        drain_text();

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            stall_mode = stall_mode_e'($urandom_range(0, 2));
            gaps_on    = ($urandom_range(0, 3) != 0);
            dump_len   = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 48)
                                                     : $urandom_range(1, 20);
            for (i = 0; i < dump_len; i++)
            begin
                send_byte(pick_byte(), i == dump_len - 1);
                pace_sender();
            end
            sent += dump_len;
            if ($urandom_range(0, 5) == 0)
            begin
                drain_text();
            end
        end

        drain_text();
        repeat (DRAIN_TAIL) @(negedge clk);
        board.close_out();
        $display("run covered %0d bytes in %0d dumps, %0d character pairs checked",
                 board.bytes_seen, board.dumps_seen, board.pairs_checked);
        $display("receiver stalled in three patterns, sender ran in bursts with gaps");
        if (board.errors == 0)
        begin
            $display("hex_dump_formatter_unit verification clean");
        end
        else
        begin
            $display("hex_dump_formatter_unit verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hdf_pkg.sv
rtl/hdf_seq.sv
rtl/hex_dump_formatter_unit.sv
verif/hex_dump_formatter_unit_tb.sv
